[design/pfc_pkg.sv]
// shared types, constants and helper functions for the playfair digraph cipher
package pfc_pkg;

  localparam int unsigned SIDE      = 5;
  localparam int unsigned CELLS     = SIDE * SIDE;
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned COORD_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 60;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [COORD_W-1:0]  coord_t;

  // cell 0 (top left) in the lowest bits, row-major
  typedef logic [CELLS-1:0][LETTER_W-1:0] square_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_LOW = 2'd0,
    REG_CELLS_MID = 2'd1,
    REG_CELL_LAST = 2'd2,
    REG_DECRYPT   = 2'd3
  } cfg_reg_e;

  // position of one letter in the square
  typedef struct packed {
    logic   found;
    coord_t row;
    coord_t col;
  } loc_t;

  // one step along a row or column with wrap, backward when decrypting
  function automatic coord_t step_coord(coord_t v, logic back);
    coord_t res;
    if (back) begin
      res = (v == '0) ? COORD_W'(SIDE - 1) : v - COORD_W'(1);
    end else begin
      res = (v == COORD_W'(SIDE - 1)) ? '0 : v + COORD_W'(1);
    end
    return res;
  endfunction

  // letter held at a row and column
  function automatic letter_t cell_pick(square_t sq, coord_t r, coord_t c);
    logic [LETTER_W-1:0] idx;
    idx = {r[COORD_W-1:0], 2'b00} + LETTER_W'(r) + LETTER_W'(c);
    return sq[idx];
  endfunction

endpackage

[design/pfc_lane.sv]
// lookup lane: finds the row and column of one letter in the key square
module pfc_lane (
  input  pfc_pkg::square_t square_i,
  input  pfc_pkg::letter_t letter_i,
  output pfc_pkg::loc_t    loc_o
);

  logic [pfc_pkg::CELLS-1:0] hit;
  logic [pfc_pkg::SIDE-1:0]  row_hit;
  logic [pfc_pkg::SIDE-1:0]  row_bits;
  pfc_pkg::coord_t           row_sel;
  pfc_pkg::coord_t           col_sel;

  // last match in row-major order wins: highest row with a hit, then highest column
  always_comb begin
    row_sel  = '0;
    col_sel  = '0;
    row_bits = '0;
    for (int c = 0; c < pfc_pkg::CELLS; c++) begin
      hit[c] = (square_i[c] == letter_i);
    end
    for (int r = 0; r < pfc_pkg::SIDE; r++) begin
      row_hit[r] = |hit[r*pfc_pkg::SIDE +: pfc_pkg::SIDE];
    end
    for (int r = 0; r < pfc_pkg::SIDE; r++) begin
      if (row_hit[r]) begin
        row_sel = pfc_pkg::COORD_W'(r);
      end
    end
    for (int r = 0; r < pfc_pkg::SIDE; r++) begin
      if (row_sel == pfc_pkg::COORD_W'(r)) begin
        row_bits = hit[r*pfc_pkg::SIDE +: pfc_pkg::SIDE];
      end
    end
    for (int c = 0; c < pfc_pkg::SIDE; c++) begin
      if (row_bits[c]) begin
        col_sel = pfc_pkg::COORD_W'(c);
      end
    end
    loc_o.found = |row_hit;
    loc_o.row   = row_sel;
    loc_o.col   = col_sel;
  end

endmodule

[design/pfc_merge.sv]
// merge stage: applies the same-row, same-column or rectangle rule to both lanes, or flags a missing letter
module pfc_merge (
  input  pfc_pkg::square_t square_i,
  input  logic             decrypt_i,
  input  pfc_pkg::loc_t    loc_a_i,
  input  pfc_pkg::loc_t    loc_b_i,
  output pfc_pkg::letter_t out_first_o,
  output pfc_pkg::letter_t out_second_o,
  output logic             not_found_o
);

  pfc_pkg::coord_t r1, c1, r2, c2;

  always_comb begin
    r1 = loc_a_i.row;
    c1 = loc_a_i.col;
    r2 = loc_b_i.row;
    c2 = loc_b_i.col;
    not_found_o = 1'b0;
    priority if (!loc_a_i.found || !loc_b_i.found) begin
      out_first_o  = '0;
      out_second_o = '0;
      not_found_o  = 1'b1;
    end else if (r1 == r2) begin
      // same row, an equal pair lands here too
      out_first_o  = pfc_pkg::cell_pick(square_i, r1, pfc_pkg::step_coord(c1, decrypt_i));
      out_second_o = pfc_pkg::cell_pick(square_i, r2, pfc_pkg::step_coord(c2, decrypt_i));
    end else if (c1 == c2) begin
      out_first_o  = pfc_pkg::cell_pick(square_i, pfc_pkg::step_coord(r1, decrypt_i), c1);
      out_second_o = pfc_pkg::cell_pick(square_i, pfc_pkg::step_coord(r2, decrypt_i), c2);
    end else begin
      out_first_o  = pfc_pkg::cell_pick(square_i, r1, c2);
      out_second_o = pfc_pkg::cell_pick(square_i, r2, c1);
    end
  end

endmodule

[design/playfair_digraph_cipher.sv]
// playfair digraph cipher top level: config registers, two lookup lanes, merge, output register
// an accepted pair is registered in the lane stage, then in the output register
// throughput: one pair per cycle unless backpressure holds the output register
// input ready drops only when the lane stage is full and the output is held by backpressure
// reset (rst_ni low, asynchronous): pipeline empty, all config registers zero
// config port is always ready; each write is registered
module playfair_digraph_cipher (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side: [4:0] first_letter, [9:5] second_letter, [15:10] zero
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [pfc_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // master side: [4:0] out_first, [9:5] out_second, [15:10] zero
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [pfc_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // master side flag: [0] not_found
  output logic [0:0]                         m_axis_tuser_o,
  // config write request
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // config registers
  logic [pfc_pkg::CFG_DATA_W-1:0] cells_low_q, cells_mid_q;
  pfc_pkg::letter_t               cell_last_q;
  logic                           decrypt_q;
  pfc_pkg::square_t               square;

  // lane stage
  logic          s1_valid_q;
  pfc_pkg::loc_t loc_a_q, loc_b_q;
  pfc_pkg::loc_t loc_a_d, loc_b_d;

  // output register
  logic             out_valid_q;
  pfc_pkg::letter_t out_first_q, out_second_q;
  logic             not_found_q;
  pfc_pkg::letter_t out_first_d, out_second_d;
  logic             not_found_d;

  logic advance;   // output register may load
  logic s_accept;

  assign cfg_ready_o = 1'b1;

  // cells packed row-major, cell 0 in the lowest bits
  assign square = pfc_pkg::square_t'({cell_last_q, cells_mid_q, cells_low_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_low_q <= '0;
      cells_mid_q <= '0;
      cell_last_q <= '0;
      decrypt_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pfc_pkg::cfg_reg_e'(cfg_index_i))
        pfc_pkg::REG_CELLS_LOW: cells_low_q <= cfg_data_i;
        pfc_pkg::REG_CELLS_MID: cells_mid_q <= cfg_data_i;
        pfc_pkg::REG_CELL_LAST: cell_last_q <= cfg_data_i[pfc_pkg::LETTER_W-1:0];
        pfc_pkg::REG_DECRYPT:   decrypt_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline flow: output loads when empty or taken, lane stage refills behind it
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // one lane per letter of the pair
  pfc_lane u_lane_a (
    .square_i (square),
    .letter_i (s_axis_tdata_i[pfc_pkg::LETTER_W-1:0]),
    .loc_o    (loc_a_d)
  );

  pfc_lane u_lane_b (
    .square_i (square),
    .letter_i (s_axis_tdata_i[2*pfc_pkg::LETTER_W-1:pfc_pkg::LETTER_W]),
    .loc_o    (loc_b_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      loc_a_q <= loc_a_d;
      loc_b_q <= loc_b_d;
    end
  end

  // combine both lane positions into the result pair
  pfc_merge u_merge (
    .square_i     (square),
    .decrypt_i    (decrypt_q),
    .loc_a_i      (loc_a_q),
    .loc_b_i      (loc_b_q),
    .out_first_o  (out_first_d),
    .out_second_o (out_second_d),
    .not_found_o  (not_found_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_first_q  <= out_first_d;
      out_second_q <= out_second_d;
      not_found_q  <= not_found_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(pfc_pkg::OUT_DATA_W - 2*pfc_pkg::LETTER_W)'(0),
                            out_second_q, out_first_q};
  assign m_axis_tuser_o  = not_found_q;

endmodule

[design/pfc_checker.sv]
// port-level checker for the playfair digraph cipher and its bind
module pfc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [pfc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]                     m_axis_tuser_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a missing letter gives zero letters
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      m_axis_tdata_o[2*pfc_pkg::LETTER_W-1:0] == '0)
    else $error("not_found result carries nonzero letters");

  // an accepted pair reaches the output once the sink takes the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("accepted pair did not reach the output");

  // config requests never wait
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config request stalled");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (.*);

[tb/sv/tb_top.sv]
// self-checking testbench for the playfair digraph cipher: directed rules, random squares, backpressure
`timescale 1ns / 100ps

module tb_top;
  import pfc_pkg::*;

  // expected output of one letter pair
  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    miss;
  } pair_result_t;

  localparam int unsigned HOLD_CYCLES = 64;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // [4:0] first_letter, [9:5] second_letter, [15:10] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // [4:0] out_first, [9:5] out_second, [15:10] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // [0] not_found
  logic [0:0]            m_axis_tuser_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // shadow copy of the key square and mode, updated on each accepted config write
  letter_t      key_square [CELLS];
  logic         decrypt_on;
  pair_result_t expected_pairs [$];

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  bit           hold_req = 1'b0;
  int unsigned  err_cnt = 0;

  playfair_digraph_cipher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // cipher prediction: last matching cell wins, equal pair counts as same row
  function automatic pair_result_t encipher_pair(letter_t a, letter_t b);
    pair_result_t res;
    int pa, pb, ra, ca, rb, cb, shift;
    bit fa, fb;
    pa = 0;
    pb = 0;
    fa = 1'b0;
    fb = 1'b0;
    for (int c = 0; c < CELLS; c++) begin
      if (key_square[c] == a) begin
        pa = c;
        fa = 1'b1;
      end
      if (key_square[c] == b) begin
        pb = c;
        fb = 1'b1;
      end
    end
    res = '0;
    if (!fa || !fb) begin
      res.miss = 1'b1;
      return res;
    end
    // a backward step of one is a forward step of side minus one
    shift = decrypt_on ? SIDE - 1 : 1;
    ra = pa / SIDE;
    ca = pa % SIDE;
    rb = pb / SIDE;
    cb = pb % SIDE;
    if (ra == rb) begin
      res.first  = key_square[ra * SIDE + (ca + shift) % SIDE];
      res.second = key_square[rb * SIDE + (cb + shift) % SIDE];
    end else if (ca == cb) begin
      res.first  = key_square[((ra + shift) % SIDE) * SIDE + ca];
      res.second = key_square[((rb + shift) % SIDE) * SIDE + cb];
    end else begin
      // rectangle rule: keep own row, take the other letter's column
      res.first  = key_square[ra * SIDE + cb];
      res.second = key_square[rb * SIDE + ca];
    end
    return res;
  endfunction

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker: each accepted result against the oldest prediction
  always @(posedge clk_i) begin : check_results
    pair_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_pairs.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %b",
               m_axis_tdata_o, m_axis_tuser_o);
        err_cnt++;
      end else begin
        want = expected_pairs.pop_front();
        if (m_axis_tdata_o[4:0] !== want.first) begin
          $error("out_first: expected %0d, got %0d", want.first, m_axis_tdata_o[4:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[9:5] !== want.second) begin
          $error("out_second: expected %0d, got %0d", want.second, m_axis_tdata_o[9:5]);
          err_cnt++;
        end
        if (m_axis_tuser_o[0] !== want.miss) begin
          $error("not_found: expected %0d, got %0d", want.miss, m_axis_tuser_o[0]);
          err_cnt++;
        end
      end
    end
  end

  // one config write; the shadow copy follows once the write is taken
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CELLS_LOW: begin
        for (int c = 0; c < 12; c++) key_square[c] = data[5 * c +: 5];
      end
      REG_CELLS_MID: begin
        for (int c = 0; c < 12; c++) key_square[12 + c] = data[5 * c +: 5];
      end
      REG_CELL_LAST: key_square[CELLS - 1] = data[4:0];
      REG_DECRYPT:   decrypt_on = data[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // program all four registers from a cell array
  task automatic load_square(input letter_t cells [CELLS], input logic mode);
    logic [CFG_DATA_W-1:0] low, mid;
    low = '0;
    mid = '0;
    for (int c = 0; c < 12; c++) begin
      low[5 * c +: 5] = cells[c];
      mid[5 * c +: 5] = cells[12 + c];
    end
    write_reg(REG_CELLS_LOW, low);
    write_reg(REG_CELLS_MID, mid);
    write_reg(REG_CELL_LAST, CFG_DATA_W'(cells[CELLS - 1]));
    write_reg(REG_DECRYPT, CFG_DATA_W'(mode));
  endtask

  // offer one pair, with random idle cycles ahead of it
  task automatic send_pair(input letter_t a, input letter_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, b, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_pairs.push_back(encipher_pair(a, b));
  endtask

  // stop offering and wait until every result is back and the pipeline is empty
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // pairs drawn mostly from the square so that each rule gets hit
  task automatic send_random_pair();
    int pick, row, col, ca, cb;
    letter_t a, b;
    pick = $urandom_range(9);
    row  = $urandom_range(SIDE - 1);
    col  = $urandom_range(SIDE - 1);
    ca   = $urandom_range(SIDE - 1);
    cb   = $urandom_range(SIDE - 1);
    case (pick)
      0, 1: begin
        a = key_square[row * SIDE + ca];
        b = key_square[row * SIDE + cb];
      end
      2, 3: begin
        a = key_square[ca * SIDE + col];
        b = key_square[cb * SIDE + col];
      end
      4: begin
        a = key_square[row * SIDE + col];
        b = a;
      end
      5, 6, 7: begin
        a = key_square[$urandom_range(CELLS - 1)];
        b = key_square[$urandom_range(CELLS - 1)];
      end
      default: begin
        // raw values, including letters absent from the square and 26 to 31
        a = letter_t'($urandom_range(31));
        b = letter_t'($urandom_range(31));
      end
    endcase
    send_pair(a, b);
  endtask

  // standard square: alphabet without j (letter 9)
  function automatic void plain_square(output letter_t cells [CELLS]);
    for (int c = 0; c < CELLS; c++) cells[c] = letter_t'(c < 9 ? c : c + 1);
  endfunction

  // registers still at their reset value: every cell holds letter 0
  task automatic test_reset_state();
    key_square = '{default: '0};
    decrypt_on = 1'b0;
    send_pair(5'd0, 5'd0);
    send_pair(5'd0, 5'd5);
    send_pair(5'd31, 5'd0);
    settle();
  endtask

  // row, column and rectangle rules, wraps, equal pairs and misses, both directions
  task automatic test_directed_rules();
    letter_t cells [CELLS];
    letter_t firsts [10]  = '{5'd0, 5'd4, 5'd0, 5'd25, 5'd25, 5'd0, 5'd9, 5'd3, 5'd31, 5'd7};
    letter_t seconds [10] = '{5'd4, 5'd0, 5'd21, 5'd0, 5'd25, 5'd0, 5'd3, 5'd9, 5'd26, 5'd18};
    plain_square(cells);
    for (int mode = 0; mode < 2; mode++) begin
      load_square(cells, logic'(mode));
      foreach (firsts[i]) send_pair(firsts[i], seconds[i]);
      settle();
    end
  endtask

  // duplicate cells and the largest values: all ones except a 25 in the corner
  task automatic test_duplicate_cells();
    letter_t cells [CELLS];
    cells = '{default: 5'd31};
    cells[CELLS - 1] = 5'd25;
    load_square(cells, 1'b0);
    send_pair(5'd31, 5'd25);
    send_pair(5'd31, 5'd31);
    settle();
  endtask

  // random squares and modes, each followed by a burst of pairs
  task automatic test_random_traffic(input int rounds, input int pairs_per_round);
    letter_t cells [CELLS];
    letter_t pool [26];
    letter_t tmp;
    int kind, j;
    for (int r = 0; r < rounds; r++) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        // shuffled alphabet, one letter left out
        for (int i = 0; i < 26; i++) pool[i] = letter_t'(i);
        for (int i = 25; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = pool[i];
          pool[i] = pool[j];
          pool[j] = tmp;
        end
        for (int c = 0; c < CELLS; c++) cells[c] = pool[c];
      end else if (kind < 9) begin
        // arbitrary 5-bit cells: duplicates and values above 25
        for (int c = 0; c < CELLS; c++) cells[c] = letter_t'($urandom_range(31));
      end else begin
        cells = '{default: ($urandom_range(1) ? 5'd31 : 5'd0)};
        cells[CELLS - 1] = letter_t'($urandom_range(1) ? 25 : 0);
      end
      load_square(cells, logic'($urandom_range(1)));
      repeat (pairs_per_round) send_random_pair();
      settle();
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (40) send_random_pair();
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 32;
    recv_stall_pct = 75;
    test_reset_state();
    test_directed_rules();
    test_duplicate_cells();
    test_random_traffic(5, 110);

    send_idle_pct  = 75;
    recv_stall_pct = 32;
    test_random_traffic(5, 110);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_random_traffic(5, 110);

    repeat (8) @(posedge clk_i);
    if (expected_pairs.size() != 0) begin
      $error("%0d results never arrived", expected_pairs.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
